>>> rtl/isotp_pkg.sv
package isotp_pkg;

  localparam int unsigned CAN_ID_W = 29;

  localparam logic [11:0] MAX_PAYLOAD = 12'd4092;
  localparam logic [11:0] SINGLE_MAX  = 12'd4;
  localparam logic [11:0] PCI_OVERHEAD = 12'd3;

  // protocol control codes
  localparam logic [7:0] PCI_FIRST  = 8'h10;
  localparam logic [3:0] PCI_CONSEC = 4'h2;

  localparam logic [3:0] FRAME_BYTES = 4'd8;
  localparam logic [3:0] SINGLE_HDR  = 4'd4;
  localparam logic [3:0] FIRST_HDR   = 4'd5;
  localparam logic [3:0] SEQ_FIRST   = 4'd1;

  typedef struct packed {
    logic [7:0][7:0] data;
    logic [3:0]      length;
    logic            done;
  } frame_t;

endpackage

>>> rtl/isotp_req_if.sv
interface isotp_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  service_id;
  logic [15:0] data_identifier;
  logic [11:0] message_length;
  logic [7:0]  payload_byte;

  modport source (output valid, service_id, data_identifier, message_length, payload_byte,
                  input ready);
  modport sink (input valid, service_id, data_identifier, message_length, payload_byte,
                output ready);
  modport mon (input valid, ready, service_id, data_identifier, message_length, payload_byte);
endinterface

>>> rtl/isotp_frame_if.sv
interface isotp_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte0;
  logic [7:0] frame_byte1;
  logic [7:0] frame_byte2;
  logic [7:0] frame_byte3;
  logic [7:0] frame_byte4;
  logic [7:0] frame_byte5;
  logic [7:0] frame_byte6;
  logic [7:0] frame_byte7;
  logic [3:0] frame_length;
  logic       message_done;

  modport source (output valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                  frame_byte4, frame_byte5, frame_byte6, frame_byte7, frame_length,
                  message_done, input ready);
  modport sink (input valid, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
                frame_byte4, frame_byte5, frame_byte6, frame_byte7, frame_length,
                message_done, output ready);
  modport mon (input valid, ready, frame_byte0, frame_byte1, frame_byte2, frame_byte3,
               frame_byte4, frame_byte5, frame_byte6, frame_byte7, frame_length,
               message_done);
endinterface

>>> rtl/isotp_did_message_segmenter.sv
// Packs a diagnostic request (service id, 16-bit data identifier, payload)
// into classic 8-byte CAN frames with ISO 15765-2 transmit segmentation.
// req channel: one payload byte per request; service_id, data_identifier
// and message_length are sampled only on the first byte of a message.
// frame channel: one frame with its bytes, frame_length and message_done,
// which marks the last frame of the message. Unused bytes read as zero.
// cfg_write / cfg_data load the 29-bit CAN identifier of the stream.
// Throughput: one payload byte per cycle, sustained while the receiver
// keeps up. A byte is taken whenever the output register is
// empty or being drained in the same cycle.
// A frame is registered and appears in the cycle after the request carrying
// the byte that fills it or ends the message.
// Reset clears the message state, sets the sequence number to one and
// empties the output register; no request is lost across frames.
// When the receiver stalls with a frame held, req.ready stays low until the
// frame is taken; the held frame does not change.
module isotp_did_message_segmenter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [isotp_pkg::CAN_ID_W-1:0]     cfg_data,
  isotp_req_if.sink                          req,
  isotp_frame_if.source                      frame
);

  logic [isotp_pkg::CAN_ID_W-1:0] can_identifier;
  logic                           free;
  logic                           accept;
  logic                           emit;
  isotp_pkg::frame_t              frame_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      can_identifier <= '0;
    end else if (cfg_write) begin
      can_identifier <= cfg_data;
    end
  end

  assign req.ready = free;
  assign accept    = req.valid && free;

  isotp_seg_core u_core (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .service_id      (req.service_id),
    .data_identifier (req.data_identifier),
    .message_length  (req.message_length),
    .payload_byte    (req.payload_byte),
    .emit            (emit),
    .frame_d         (frame_d)
  );

  isotp_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept && emit),
    .frame_d (frame_d),
    .free    (free),
    .frame   (frame)
  );

endmodule

>>> rtl/isotp_seg_core.sv
module isotp_seg_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          service_id,
  input  logic [15:0]         data_identifier,
  input  logic [11:0]         message_length,
  input  logic [7:0]          payload_byte,
  output logic                emit,
  output isotp_pkg::frame_t   frame_d
);

  logic [11:0]     bytes_taken;
  logic [3:0]      seq_nibble;
  logic [7:0][7:0] buffer;
  logic [3:0]      fill;
  logic [11:0]     held_length;

  logic            start;
  logic [11:0]     len_fix;
  logic [11:0]     total;
  logic [11:0]     cur_len;
  logic [3:0]      seq_cur;
  logic [7:0][7:0] base;
  logic [3:0]      base_fill;
  logic [7:0][7:0] built;
  logic [3:0]      built_fill;
  logic [11:0]     taken;
  logic            done;

  always_comb begin
    start = (bytes_taken == 12'd0);
    priority if (message_length == 12'd0) begin
      len_fix = 12'd1;
    end else if (message_length > isotp_pkg::MAX_PAYLOAD) begin
      len_fix = isotp_pkg::MAX_PAYLOAD;
    end else begin
      len_fix = message_length;
    end
    total = len_fix + isotp_pkg::PCI_OVERHEAD;

    base      = buffer;
    base_fill = fill;
    cur_len   = held_length;
    seq_cur   = seq_nibble;
    if (start) begin
      base    = '0;
      cur_len = len_fix;
      seq_cur = isotp_pkg::SEQ_FIRST;
      if (len_fix <= isotp_pkg::SINGLE_MAX) begin
        base[0]   = total[7:0];
        base[1]   = service_id;
        base[2]   = data_identifier[15:8];
        base[3]   = data_identifier[7:0];
        base_fill = isotp_pkg::SINGLE_HDR;
      end else begin
        base[0]   = isotp_pkg::PCI_FIRST | {4'h0, total[11:8]};
        base[1]   = total[7:0];
        base[2]   = service_id;
        base[3]   = data_identifier[15:8];
        base[4]   = data_identifier[7:0];
        base_fill = isotp_pkg::FIRST_HDR;
      end
    end

    // drop the payload byte into the next free slot
    for (int j = 0; j < 8; j++) begin
      built[j] = (base_fill < isotp_pkg::FRAME_BYTES && base_fill == 4'(j)) ?
                 payload_byte : base[j];
    end
    built_fill = (base_fill < isotp_pkg::FRAME_BYTES) ? base_fill + 4'd1 : base_fill;

    taken = bytes_taken + 12'd1;
    done  = (taken >= cur_len);
    emit  = (built_fill == isotp_pkg::FRAME_BYTES) || done;

    frame_d.data   = built;
    frame_d.length = built_fill;
    frame_d.done   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_taken <= 12'd0;
      seq_nibble  <= isotp_pkg::SEQ_FIRST;
      fill        <= 4'd0;
      held_length <= 12'd0;
      buffer      <= '0;
    end else if (accept) begin
      held_length <= cur_len;
      if (emit) begin
        buffer <= '0;
        if (done) begin
          bytes_taken <= 12'd0;
          fill        <= 4'd0;
          seq_nibble  <= isotp_pkg::SEQ_FIRST;
        end else begin
          // open the next consecutive frame
          buffer[0]   <= {isotp_pkg::PCI_CONSEC, seq_cur};
          seq_nibble  <= seq_cur + 4'd1;
          fill        <= 4'd1;
          bytes_taken <= taken;
        end
      end else begin
        buffer      <= built;
        fill        <= built_fill;
        bytes_taken <= taken;
        seq_nibble  <= seq_cur;
      end
    end
  end

endmodule

>>> rtl/isotp_out_reg.sv
module isotp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  isotp_pkg::frame_t  frame_d,
  output logic               free,
  isotp_frame_if.source      frame
);

  logic              valid;
  isotp_pkg::frame_t held;

  assign free = !valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (frame.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= frame_d;
    end
  end

  assign frame.valid        = valid;
  assign frame.frame_byte0  = held.data[0];
  assign frame.frame_byte1  = held.data[1];
  assign frame.frame_byte2  = held.data[2];
  assign frame.frame_byte3  = held.data[3];
  assign frame.frame_byte4  = held.data[4];
  assign frame.frame_byte5  = held.data[5];
  assign frame.frame_byte6  = held.data[6];
  assign frame.frame_byte7  = held.data[7];
  assign frame.frame_length = held.length;
  assign frame.message_done = held.done;

endmodule

>>> rtl/isotp_seg_checker.sv
module isotp_seg_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       frame_valid,
  input logic       frame_ready,
  input logic [7:0] frame_byte0,
  input logic [7:0] frame_byte7,
  input logic [3:0] frame_length,
  input logic       message_done
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !frame_valid)
    else $error("frame valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |=> frame_valid && $stable(frame_byte0)
      && $stable(frame_length) && $stable(message_done))
    else $error("stalled frame changed");

  // only the last frame of a message may be short
  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !message_done |-> frame_length == 4'd8)
    else $error("short frame before end of message");

  a_short_zero: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_length != 4'd8 |-> frame_byte7 == 8'h00)
    else $error("unused frame byte not zero");

  // a held frame blocks new requests
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_ready |-> !req_ready)
    else $error("request taken while frame stalled");

endmodule

bind isotp_did_message_segmenter isotp_seg_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .req_ready    (req.ready),
  .frame_valid  (frame.valid),
  .frame_ready  (frame.ready),
  .frame_byte0  (frame.frame_byte0),
  .frame_byte7  (frame.frame_byte7),
  .frame_length (frame.frame_length),
  .message_done (frame.message_done)
);

>>> tb/testbench.sv
class frame_scoreboard;
  logic [12:0]       bytes_taken;
  logic [12:0]       msg_len;
  logic [3:0]        seq_num;
  logic [3:0]        fill;
  logic [7:0][7:0]   build;
  logic [28:0]       can_id;
  isotp_pkg::frame_t pending_frames[$];
  int                failures;

  function new();
    bytes_taken = '0;
    msg_len     = '0;
    seq_num     = isotp_pkg::SEQ_FIRST;
    fill        = '0;
    build       = '0;
    can_id      = '0;
    failures    = 0;
  endfunction

  // advance the segmenter state by one accepted request
  function void note_request(logic [7:0] sid, logic [15:0] did, logic [11:0] len_field,
                             logic [7:0] db);
    logic [11:0]       n;
    logic [12:0]       total;
    logic              done;
    isotp_pkg::frame_t f;
    if (bytes_taken == 0) begin
      n = len_field;
      if (n == 0) n = 12'd1;
      if (n > isotp_pkg::MAX_PAYLOAD) n = isotp_pkg::MAX_PAYLOAD;
      msg_len = {1'b0, n};
      seq_num = isotp_pkg::SEQ_FIRST;
      build = '0;
      if (n <= isotp_pkg::SINGLE_MAX) begin
        build[0] = 8'(n + isotp_pkg::PCI_OVERHEAD);
        build[1] = sid;
        build[2] = did[15:8];
        build[3] = did[7:0];
        fill = isotp_pkg::SINGLE_HDR;
      end else begin
        total = {1'b0, n} + 13'(isotp_pkg::PCI_OVERHEAD);
        build[0] = isotp_pkg::PCI_FIRST | {4'h0, total[11:8]};
        build[1] = total[7:0];
        build[2] = sid;
        build[3] = did[15:8];
        build[4] = did[7:0];
        fill = isotp_pkg::FIRST_HDR;
      end
    end
    if (fill < isotp_pkg::FRAME_BYTES) begin
      build[fill[2:0]] = db;
      fill = fill + 4'd1;
    end
    bytes_taken = bytes_taken + 13'd1;
    done = (bytes_taken >= msg_len);
    if (fill < isotp_pkg::FRAME_BYTES && !done) return;
    f.data   = build;
    f.length = fill;
    f.done   = done;
    pending_frames = {pending_frames, f};
    build = '0;
    if (done) begin
      bytes_taken = '0;
      fill = '0;
      seq_num = isotp_pkg::SEQ_FIRST;
    end else begin
      // next consecutive frame header, sequence wraps to zero after 15
      build[0] = {isotp_pkg::PCI_CONSEC, seq_num};
      seq_num = seq_num + 4'd1;
      fill = 4'd1;
    end
  endfunction

  function void check_frame(isotp_pkg::frame_t got);
    isotp_pkg::frame_t want;
    if (pending_frames.size() == 0) begin
      if (failures < 10)
        $display("unexpected frame: data %h length %0d done %b", got.data, got.length,
                 got.done);
      failures++;
      return;
    end
    want = pending_frames.pop_front();
    if (got.data !== want.data || got.length !== want.length || got.done !== want.done) begin
      // data printed with byte 7 leftmost
      if (failures < 10)
        $display("frame mismatch: exp %h len %0d done %b, got %h len %0d done %b",
                 want.data, want.length, want.done, got.data, got.length, got.done);
      failures++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_ALTERNATE} fill_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [28:0] cfg_data;
  int          cycles = 0;
  int          items_sent = 0;

  frame_scoreboard sb;

  isotp_req_if   req_ch ();
  isotp_frame_if frame_ch ();

  isotp_did_message_segmenter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .frame     (frame_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] sid, logic [15:0] did, logic [11:0] len_field,
                           logic [7:0] db, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid           <= 1'b1;
    req_ch.service_id      <= sid;
    req_ch.data_identifier <= did;
    req_ch.message_length  <= len_field;
    req_ch.payload_byte    <= db;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(sid, did, len_field, db);
    items_sent++;
  endtask

  task automatic send_message(logic [7:0] sid, logic [15:0] did, logic [11:0] len_field,
                              fill_kind_t kind);
    int         n;
    bit         quiet;
    logic [7:0] db;
    if (len_field == 0) n = 1;
    else if (len_field > isotp_pkg::MAX_PAYLOAD) n = isotp_pkg::MAX_PAYLOAD;
    else n = len_field;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        FILL_ZERO:      db = 8'h00;
        FILL_ONES:      db = 8'hFF;
        FILL_ALTERNATE: db = i[0] ? 8'h55 : 8'hAA;
        default:        db = 8'($urandom_range(0, 255));
      endcase
      if (i == 0) begin
        send_byte(sid, did, len_field, db, quiet);
      end else begin
        // header fields past the first byte must be ignored
        send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                  12'($urandom_range(0, 4095)), db, quiet);
      end
    end
  endtask

  task automatic send_random_message();
    logic [11:0] len_field;
    case ($urandom_range(0, 9))
      0:          len_field = 12'd0;
      1, 2, 3, 4: len_field = 12'($urandom_range(1, 4));
      5, 6, 7:    len_field = 12'($urandom_range(5, 24));
      8:          len_field = 12'($urandom_range(25, 60));
      default:    len_field = 12'($urandom_range(100, 140));
    endcase
    send_message(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), len_field,
                 FILL_RANDOM);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_can_id(logic [28:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.can_id = value;
  endtask

  initial begin : frame_sink
    int                gap;
    int                stretch;
    bit                quiet;
    isotp_pkg::frame_t got;
    stretch = 0;
    quiet = 1'b0;
    frame_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stretch == 0) begin
        stretch = $urandom_range(1, 40);
        quiet = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_ch.ready <= 1'b1;
      do @(posedge clk); while (!frame_ch.valid);
      got.data[0] = frame_ch.frame_byte0;
      got.data[1] = frame_ch.frame_byte1;
      got.data[2] = frame_ch.frame_byte2;
      got.data[3] = frame_ch.frame_byte3;
      got.data[4] = frame_ch.frame_byte4;
      got.data[5] = frame_ch.frame_byte5;
      got.data[6] = frame_ch.frame_byte6;
      got.data[7] = frame_ch.frame_byte7;
      got.length  = frame_ch.frame_length;
      got.done    = frame_ch.message_done;
      sb.check_frame(got);
    end
  end

  initial begin
    sb = new();
    rst                    <= 1'b1;
    cfg_write              <= 1'b0;
    cfg_data               <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.service_id      <= '0;
    req_ch.data_identifier <= '0;
    req_ch.message_length  <= '0;
    req_ch.payload_byte    <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_can_id(29'h1FFF_FFFF);

    // zero length, field extremes, single/first frame boundaries, full consecutive frame
    send_message(8'h00, 16'h0000, 12'd0, FILL_ZERO);
    send_message(8'hFF, 16'hFFFF, 12'd1, FILL_ONES);
    send_message(8'hA5, 16'h1234, 12'd4, FILL_ALTERNATE);
    send_message(8'h22, 16'hF00F, 12'd5, FILL_RANDOM);
    send_message(8'h3E, 16'hABCD, 12'd10, FILL_ONES);
    wait_drained();
    write_can_id(29'h0);

    while (items_sent < 500) begin
      send_random_message();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    write_can_id(29'($urandom_range(0, 29'h1FFF_FFFF)));

    while (items_sent < 980) begin
      send_random_message();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    wait_drained();
    write_can_id(29'($urandom_range(0, 29'h1FFF_FFFF)));

    // long message: upper length nibble set, sequence wraps several times
    send_message(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 12'd509,
                 FILL_RANDOM);
    send_random_message();
    wait_drained();
    repeat (8) @(posedge clk);

    if (sb.failures == 0 && sb.pending_frames.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
